[rtl/core/esfl_pkg.sv]
`timescale 1ns / 1ps
// esfl_pkg: shared types, widths and command/status structs for the
// edge shared face lookup block; no dependencies

package esfl_pkg;

  localparam int NumVerts         = 4096;
  localparam int VertW            = 12;
  localparam int FaceW            = 13;
  localparam int CountW           = 7;
  localparam int ListDepthDefault = 64;

  localparam logic [CountW-1:0] CountMax = '1;

  localparam logic FuncAppend = 1'b0;
  localparam logic FuncQuery  = 1'b1;

  typedef struct packed {
    logic             func;
    logic [VertW-1:0] vertex_a;
    logic [VertW-1:0] vertex_b;
    logic [VertW-1:0] vertex_c;
    logic [FaceW-1:0] face_id;
  } req_t;

  typedef struct packed {
    logic [FaceW-1:0]  face_one;
    logic [FaceW-1:0]  face_two;
    logic [CountW-1:0] match_count;
    logic              overflow;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic clr;
    logic len_rd;
    logic app_wr;
    logic cap_la;
    logic sel;
    logic walk_rd;
    logic key_ld;
    logic probe_rd;
    logic probe_cmp;
    logic next_i;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic corner_last;
    logic walk_done;
    logic other_empty;
    logic probe_end;
  } sts_t;

endpackage

[rtl/core/esfl_ctrl.sv]
`timescale 1ns / 1ps
// esfl_ctrl: sequencer for clearing, appends and edge queries
// depends on esfl_pkg

module esfl_ctrl import esfl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic func_i,
  input  sts_t sts_i,
  output logic busy_o,
  output logic done_o,
  output cmd_t cmd_o
);

  localparam logic [3:0] StClr  = 4'd0;
  localparam logic [3:0] StIdle = 4'd1;
  localparam logic [3:0] StARd  = 4'd2;
  localparam logic [3:0] StAWr  = 4'd3;
  localparam logic [3:0] StQLa  = 4'd4;
  localparam logic [3:0] StQLb  = 4'd5;
  localparam logic [3:0] StQSel = 4'd6;
  localparam logic [3:0] StWChk = 4'd7;
  localparam logic [3:0] StWKey = 4'd8;
  localparam logic [3:0] StSRd  = 4'd9;
  localparam logic [3:0] StSCmp = 4'd10;
  localparam logic [3:0] StDone = 4'd11;

  logic [3:0] state_d, state_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      StClr: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_done) state_d = StIdle;
      end
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = (func_i == FuncQuery) ? StQLa : StARd;
        end
      end
      StARd: begin
        cmd_o.len_rd = 1'b1;
        state_d      = StAWr;
      end
      StAWr: begin
        cmd_o.app_wr = 1'b1;
        state_d      = sts_i.corner_last ? StDone : StARd;
      end
      StQLa: begin
        cmd_o.len_rd = 1'b1;
        state_d      = StQLb;
      end
      StQLb: begin
        cmd_o.cap_la = 1'b1;
        cmd_o.len_rd = 1'b1;
        state_d      = StQSel;
      end
      StQSel: begin
        cmd_o.sel = 1'b1;
        state_d   = StWChk;
      end
      StWChk: begin
        if (sts_i.walk_done) begin
          state_d = StDone;
        end else begin
          cmd_o.walk_rd = 1'b1;
          state_d       = StWKey;
        end
      end
      StWKey: begin
        cmd_o.key_ld = 1'b1;
        if (sts_i.other_empty) begin
          cmd_o.next_i = 1'b1;
          state_d      = StWChk;
        end else begin
          state_d = StSRd;
        end
      end
      StSRd: begin
        cmd_o.probe_rd = 1'b1;
        state_d        = StSCmp;
      end
      StSCmp: begin
        cmd_o.probe_cmp = 1'b1;
        if (sts_i.probe_end) begin
          cmd_o.next_i = 1'b1;
          state_d      = StWChk;
        end else begin
          state_d = StSRd;
        end
      end
      StDone: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClr;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != StIdle);
  assign done_o = (state_q == StDone);

endmodule

[rtl/core/esfl_dp.sv]
`timescale 1ns / 1ps
// esfl_dp: list length and face list memories, search registers, results
// depends on esfl_pkg

module esfl_dp import esfl_pkg::*; #(
  parameter int ListDepth = ListDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output rsp_t result_o
);

  localparam int IdxW  = $clog2(ListDepth);
  localparam int LenW  = $clog2(ListDepth + 1);
  localparam int AddrW = $clog2(NumVerts * ListDepth);

  localparam logic [LenW-1:0]  DepthLen = LenW'(ListDepth);
  localparam logic [VertW-1:0] LastVert = VertW'(NumVerts - 1);

  logic [LenW-1:0]  len_mem [NumVerts];
  logic [FaceW-1:0] face_mem [NumVerts * ListDepth];

  req_t              req_q;
  logic [1:0]        corner_q;
  logic [VertW-1:0]  clr_cnt_q;
  logic [LenW-1:0]   len_rdata_q;
  logic [FaceW-1:0]  face_rdata_q;
  logic [LenW-1:0]   la_q;
  logic [VertW-1:0]  walk_v_q, other_v_q;
  logic [LenW-1:0]   walk_n_q, other_n_q;
  logic [LenW-1:0]   i_q, lo_q, hi_q;
  logic [FaceW-1:0]  key_q;
  logic [FaceW-1:0]  f1_q, f2_q;
  logic [CountW-1:0] cnt_q;
  logic              found_q, ovf_q;

  logic [VertW-1:0] corner_v;
  logic [VertW-1:0] len_ra;
  logic [LenW:0]    mid_sum;
  logic [LenW-1:0]  mid, mid_p1;
  logic             hit, less, room;
  logic             len_we, face_we, face_re;
  logic [VertW-1:0] len_wa;
  logic [LenW-1:0]  len_wd;
  logic [AddrW-1:0] face_wa, face_ra;

  function automatic logic [AddrW-1:0] face_addr(logic [VertW-1:0] v, logic [IdxW-1:0] idx);
    face_addr = AddrW'(v) * AddrW'(ListDepth) + AddrW'(idx);
  endfunction

  always_comb begin
    unique case (corner_q)
      2'd0:    corner_v = req_q.vertex_a;
      2'd1:    corner_v = req_q.vertex_b;
      default: corner_v = req_q.vertex_c;
    endcase
  end

  // second length read of a query goes to the second endpoint
  assign len_ra  = cmd_i.cap_la ? req_q.vertex_b : corner_v;

  // inclusive-range midpoint, hi_q holds the exclusive bound
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} - (LenW + 1)'(1);
  assign mid     = mid_sum[LenW:1];
  assign mid_p1  = mid + LenW'(1);
  assign hit     = (face_rdata_q == key_q);
  assign less    = (face_rdata_q < key_q);
  assign room    = (len_rdata_q < DepthLen);

  assign len_we  = cmd_i.clr || (cmd_i.app_wr && room);
  assign len_wa  = cmd_i.clr ? clr_cnt_q : corner_v;
  assign len_wd  = cmd_i.clr ? '0 : len_rdata_q + LenW'(1);
  assign face_we = cmd_i.app_wr && room;
  assign face_wa = face_addr(corner_v, len_rdata_q[IdxW-1:0]);
  assign face_re = cmd_i.walk_rd || cmd_i.probe_rd;
  assign face_ra = cmd_i.walk_rd ? face_addr(walk_v_q, i_q[IdxW-1:0])
                                 : face_addr(other_v_q, mid[IdxW-1:0]);

  always_ff @(posedge clk_i) begin
    if (len_we) len_mem[len_wa] <= len_wd;
    if (cmd_i.len_rd) len_rdata_q <= len_mem[len_ra];
  end

  always_ff @(posedge clk_i) begin
    if (face_we) face_mem[face_wa] <= req_q.face_id;
    if (face_re) face_rdata_q <= face_mem[face_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr) begin
      clr_cnt_q <= clr_cnt_q + VertW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q    <= req_i;
      corner_q <= '0;
      i_q      <= '0;
      cnt_q    <= '0;
      found_q  <= 1'b0;
      f1_q     <= '0;
      f2_q     <= '0;
      ovf_q    <= 1'b0;
    end
    if (cmd_i.app_wr) begin
      corner_q <= corner_q + 2'd1;
      if (!room) ovf_q <= 1'b1;
    end
    if (cmd_i.cap_la) begin
      la_q <= len_rdata_q;
    end
    if (cmd_i.sel) begin
      if (len_rdata_q < la_q) begin
        walk_v_q  <= req_q.vertex_b;
        other_v_q <= req_q.vertex_a;
        walk_n_q  <= len_rdata_q;
        other_n_q <= la_q;
      end else begin
        walk_v_q  <= req_q.vertex_a;
        other_v_q <= req_q.vertex_b;
        walk_n_q  <= la_q;
        other_n_q <= len_rdata_q;
      end
    end
    if (cmd_i.key_ld) begin
      key_q <= face_rdata_q;
      lo_q  <= '0;
      hi_q  <= other_n_q;
    end
    if (cmd_i.probe_cmp) begin
      if (hit) begin
        if (cnt_q != CountMax) cnt_q <= cnt_q + CountW'(1);
        if (!found_q) begin
          f1_q    <= key_q;
          found_q <= 1'b1;
        end else begin
          f2_q <= key_q;
        end
      end else if (less) begin
        lo_q <= mid_p1;
      end else begin
        hi_q <= mid;
      end
    end
    if (cmd_i.next_i) i_q <= i_q + LenW'(1);
  end

  always_comb begin
    sts_o.clr_done    = (clr_cnt_q == LastVert);
    sts_o.corner_last = (corner_q == 2'd2);
    sts_o.walk_done   = (i_q == walk_n_q);
    sts_o.other_empty = (other_n_q == '0);
    sts_o.probe_end   = hit || (less ? (mid_p1 >= hi_q) : (lo_q >= mid));
  end

  always_comb begin
    result_o.face_one    = f1_q;
    result_o.face_two    = f2_q;
    result_o.match_count = cnt_q;
    result_o.overflow    = ovf_q;
  end

endmodule

[rtl/core/edge_shared_face_lookup.sv]
`timescale 1ns / 1ps
// edge_shared_face_lookup: per-vertex face lists with append and edge query
// append: writes the face to each corner's list that has room, in turn, then strobes done; busy until then
// query: reads both endpoint lengths, walks the shorter list (vertex_a on a tie) and binary searches
//   the other list for each walked entry; at most one face memory read per cycle
// reset: busy while the length table is cleared; results cannot stall

module edge_shared_face_lookup import esfl_pkg::*; #(
  parameter int ListDepth = ListDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  req_t req_i,
  output logic done_o,
  output rsp_t result_o
);

  cmd_t cmd;
  sts_t sts;

  esfl_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .func_i (req_i.func),
    .sts_i  (sts),
    .busy_o (busy_o),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  esfl_dp #(
    .ListDepth(ListDepth)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .result_o(result_o)
  );

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o)
    else $error("block not idle after result");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("request accepted without going busy");

  a_ovf_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.overflow) |-> (result_o.match_count == '0))
    else $error("overflow result carries matches");

  a_face_two_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.match_count < CountW'(2))) |-> (result_o.face_two == '0))
    else $error("second face set with fewer than two matches");

endmodule
